/* hw/rtl/psc_pkg.sv */
package psc_pkg;

  // default widths of the data path
  localparam int DATA_WIDTH_DEF    = 32;
  localparam int FRACTION_BITS_DEF = 16;

  // fixed widths: gains and limits, integral, serial digit
  localparam int COEF_W  = 32;
  localparam int SUM_W   = 48;
  localparam int DIGIT_W = 4;
  localparam int REG_IDX_W = 3;

  // register reset values
  localparam logic signed [COEF_W-1:0] RST_KP    = 32'sd52429;
  localparam logic signed [COEF_W-1:0] RST_KI    = 32'sd3277;
  localparam logic signed [COEF_W-1:0] RST_KD    = 32'sd1311;
  localparam logic [COEF_W-2:0]        RST_DT    = 31'd655;
  localparam logic [COEF_W-2:0]        RST_INVDT = 31'd6553600;
  localparam logic signed [COEF_W-1:0] RST_FLOOR = -32'sd65536;
  localparam logic signed [COEF_W-1:0] RST_CEIL  = 32'sd65536;

  // configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_KP    = 3'd0,
    REG_KI    = 3'd1,
    REG_KD    = 3'd2,
    REG_DT    = 3'd3,
    REG_INVDT = 3'd4,
    REG_FLOOR = 3'd5,
    REG_CEIL  = 3'd6
  } reg_idx_t;

endpackage

/* hw/rtl/psc_serial_mul.sv */
module psc_serial_mul import psc_pkg::*; #(
  parameter int X_WIDTH       = SUM_W,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  localparam int RES_W        = X_WIDTH + COEF_W - FRACTION_BITS + 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [X_WIDTH-1:0] x,
  input  logic signed [COEF_W:0]    c,
  output logic                     done,
  output logic signed [RES_W-1:0]  result
);

  localparam int DIGITS = COEF_W / DIGIT_W;
  localparam int CNT_W  = $clog2(DIGITS);
  localparam int PROD_W = X_WIDTH + COEF_W;
  localparam int Q_W    = PROD_W - FRACTION_BITS;

  logic [X_WIDTH-1:0]         a_mag;
  logic [X_WIDTH-1:0]         hi;
  logic [COEF_W-1:0]          lo;
  logic                       neg;
  logic                       busy;
  logic                       fin;
  logic [CNT_W-1:0]           cnt;
  logic [X_WIDTH+DIGIT_W-1:0] step_sum;
  logic [PROD_W-1:0]          prod;
  logic [Q_W-1:0]             q;
  logic [X_WIDTH-1:0]         x_mag;
  logic [COEF_W:0]            c_abs;

  // magnitudes of the operands at load
  assign x_mag = x[X_WIDTH-1] ? X_WIDTH'(-x) : X_WIDTH'(x);
  assign c_abs = c[COEF_W] ? (COEF_W+1)'(-c) : (COEF_W+1)'(c);

  // one digit of the multiplier per cycle, low digit first
  assign step_sum = (X_WIDTH+DIGIT_W)'(hi)
                  + (X_WIDTH+DIGIT_W)'(a_mag) * (X_WIDTH+DIGIT_W)'(lo[DIGIT_W-1:0]);

  // truncate toward zero on the magnitude
  assign prod = {hi, lo};
  assign q    = prod[PROD_W-1:FRACTION_BITS];

  // sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        fin  <= 1'b0;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIGITS - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // operand and partial product registers
  always_ff @(posedge clk) begin
    if (start) begin
      a_mag <= x_mag;
      hi    <= '0;
      lo    <= c_abs[COEF_W-1:0];
      neg   <= x[X_WIDTH-1] ^ c[COEF_W];
    end else if (busy) begin
      hi <= step_sum[X_WIDTH+DIGIT_W-1:DIGIT_W];
      lo <= {step_sum[DIGIT_W-1:0], lo[COEF_W-1:DIGIT_W]};
    end
  end

  // signed result
  always_ff @(posedge clk) begin
    if (fin) begin
      result <= neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    end
  end

endmodule

/* hw/rtl/pid_speed_controller_core.sv */
// an accepted word runs states INC through OUT to give its drive value
// five products of each control tick share one digit-serial multiplier
//   at 4 bits a cycle; a new word is accepted only in the idle state
// a finished drive value waits in the output register while the next tick runs
// reset (synchronous): gains and limits to defaults, integral and last error to zero
module pid_speed_controller_core import psc_pkg::*; #(
  parameter int DATA_WIDTH    = DATA_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  localparam int IN_W  = ((2 * DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((DATA_WIDTH + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_W-1:0]      s_axis_tdata,   // target_value, measured_value
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_W-1:0]     m_axis_tdata,   // drive_value
  input  logic                 cfg_write,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data
);

  localparam int DW = DATA_WIDTH;
  localparam int EW = DW + 1;
  localparam int FW = DW + 2;
  localparam int XW = (FW > SUM_W) ? FW : SUM_W;
  localparam int RW = XW + COEF_W - FRACTION_BITS + 1;
  localparam int UW = RW + 2;
  localparam int SW = SUM_W + 2;

  // integral increment limits: -2^48 and 2^48-2
  localparam logic signed [RW-1:0] INC_LO = {{(RW-SUM_W){1'b1}}, {SUM_W{1'b0}}};
  localparam logic signed [RW-1:0] INC_HI = {{(RW-SUM_W){1'b0}}, {(SUM_W-1){1'b1}}, 1'b0};
  // 48-bit signed limits
  localparam logic signed [RW-1:0] SUM_MAX_R = {{(RW-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}};
  localparam logic signed [RW-1:0] SUM_MIN_R = {{(RW-SUM_W+1){1'b1}}, {(SUM_W-1){1'b0}}};
  localparam logic signed [SW-1:0] SUM_MAX_S = {{(SW-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}};
  localparam logic signed [SW-1:0] SUM_MIN_S = {{(SW-SUM_W+1){1'b1}}, {(SUM_W-1){1'b0}}};
  // data width limits
  localparam logic signed [UW-1:0] DATA_MAX = {{(UW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [UW-1:0] DATA_MIN = {{(UW-DW+1){1'b1}}, {(DW-1){1'b0}}};

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_INC  = 8'b0000_0010,
    ST_DER  = 8'b0000_0100,
    ST_PROP = 8'b0000_1000,
    ST_INTG = 8'b0001_0000,
    ST_DRV  = 8'b0010_0000,
    ST_CEIL = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_t;

  state_t state;

  // configuration registers
  logic signed [COEF_W-1:0] kp;
  logic signed [COEF_W-1:0] ki;
  logic signed [COEF_W-1:0] kd;
  logic [COEF_W-2:0]        dt;
  logic [COEF_W-2:0]        inv_dt;
  logic signed [COEF_W-1:0] out_floor;
  logic signed [COEF_W-1:0] out_ceil;

  // controller state and working registers
  logic signed [SUM_W-1:0] error_sum;
  logic signed [EW-1:0]    last_error;
  logic signed [EW-1:0]    err;
  logic signed [FW-1:0]    diff;
  logic signed [SUM_W-1:0] deriv;
  logic signed [UW-1:0]    acc;
  logic                    mul_start;
  logic [DW-1:0]           out_data;
  logic                    out_valid;

  logic signed [DW-1:0]    target;
  logic signed [DW-1:0]    measured;
  logic signed [EW-1:0]    err_next;
  logic signed [FW-1:0]    diff_next;
  logic                    in_accept;
  logic                    out_free;

  logic signed [XW-1:0]     mul_x;
  logic signed [COEF_W:0]   mul_c;
  logic                     mul_done;
  logic signed [RW-1:0]     mul_result;

  logic signed [RW-1:0]     inc_sat;
  logic signed [SUM_W:0]    inc_n;
  logic signed [SW-1:0]     sum_wide;
  logic signed [SUM_W-1:0]  error_sum_next;
  logic signed [SUM_W-1:0]  deriv_next;
  logic signed [UW-1:0]     ceil_w;
  logic signed [UW-1:0]     floor_w;
  logic signed [UW-1:0]     floored;
  logic signed [UW-1:0]     drive_next;

  // input unpacking and error terms
  assign target    = s_axis_tdata[DW-1:0];
  assign measured  = s_axis_tdata[2*DW-1:DW];
  assign err_next  = EW'(target) - EW'(measured);
  assign diff_next = FW'(err_next) - FW'(last_error);

  assign s_axis_tready = (state == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_W'(out_data);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      kp        <= RST_KP;
      ki        <= RST_KI;
      kd        <= RST_KD;
      dt        <= RST_DT;
      inv_dt    <= RST_INVDT;
      out_floor <= RST_FLOOR;
      out_ceil  <= RST_CEIL;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_KP:    kp        <= cfg_data;
        REG_KI:    ki        <= cfg_data;
        REG_KD:    kd        <= cfg_data;
        REG_DT:    dt        <= cfg_data[COEF_W-2:0];
        REG_INVDT: inv_dt    <= cfg_data[COEF_W-2:0];
        REG_FLOOR: out_floor <= cfg_data;
        REG_CEIL:  out_ceil  <= cfg_data;
        default: ;
      endcase
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_x = XW'(err);
    mul_c = {2'b00, dt};
    case (state)
      ST_DER: begin
        mul_x = XW'(diff);
        mul_c = {2'b00, inv_dt};
      end
      ST_PROP: begin
        mul_x = XW'(err);
        mul_c = (COEF_W+1)'(kp);
      end
      ST_INTG: begin
        mul_x = XW'(error_sum);
        mul_c = (COEF_W+1)'(ki);
      end
      ST_DRV: begin
        mul_x = XW'(deriv);
        mul_c = (COEF_W+1)'(kd);
      end
      default: ;
    endcase
  end

  psc_serial_mul #(
    .X_WIDTH       (XW),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .x      (mul_x),
    .c      (mul_c),
    .done   (mul_done),
    .result (mul_result)
  );

  // saturating integral update
  always_comb begin
    if (mul_result < INC_LO) begin
      inc_sat = INC_LO;
    end else if (mul_result > INC_HI) begin
      inc_sat = INC_HI;
    end else begin
      inc_sat = mul_result;
    end
    inc_n    = inc_sat[SUM_W:0];
    sum_wide = SW'(error_sum) + SW'(inc_n);
    if (sum_wide > SUM_MAX_S) begin
      error_sum_next = SUM_MAX_S[SUM_W-1:0];
    end else if (sum_wide < SUM_MIN_S) begin
      error_sum_next = SUM_MIN_S[SUM_W-1:0];
    end else begin
      error_sum_next = sum_wide[SUM_W-1:0];
    end
  end

  // derivative saturates to 48 bits
  always_comb begin
    if (mul_result > SUM_MAX_R) begin
      deriv_next = SUM_MAX_R[SUM_W-1:0];
    end else if (mul_result < SUM_MIN_R) begin
      deriv_next = SUM_MIN_R[SUM_W-1:0];
    end else begin
      deriv_next = mul_result[SUM_W-1:0];
    end
  end

  // floor clamp then data width saturation
  assign ceil_w  = UW'(out_ceil);
  assign floor_w = UW'(out_floor);
  assign floored = (acc < floor_w) ? floor_w : acc;
  always_comb begin
    if (floored > DATA_MAX) begin
      drive_next = DATA_MAX;
    end else if (floored < DATA_MIN) begin
      drive_next = DATA_MIN;
    end else begin
      drive_next = floored;
    end
  end

  // tick sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      mul_start  <= 1'b0;
      error_sum  <= '0;
      last_error <= '0;
    end else begin
      mul_start <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            last_error <= err_next;
            mul_start  <= 1'b1;
            state      <= ST_INC;
          end
        end
        ST_INC: begin
          if (mul_done) begin
            error_sum <= error_sum_next;
            mul_start <= 1'b1;
            state     <= ST_DER;
          end
        end
        ST_DER: begin
          if (mul_done) begin
            mul_start <= 1'b1;
            state     <= ST_PROP;
          end
        end
        ST_PROP: begin
          if (mul_done) begin
            mul_start <= 1'b1;
            state     <= ST_INTG;
          end
        end
        ST_INTG: begin
          if (mul_done) begin
            mul_start <= 1'b1;
            state     <= ST_DRV;
          end
        end
        ST_DRV: begin
          if (mul_done) begin
            state <= ST_CEIL;
          end
        end
        ST_CEIL: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // data path registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      err  <= err_next;
      diff <= diff_next;
    end
    if (mul_done && state == ST_DER) begin
      deriv <= deriv_next;
    end
    // drive sum accumulates the three terms, then is clamped to the ceiling
    if (mul_done && state == ST_PROP) begin
      acc <= UW'(mul_result);
    end else if (mul_done && (state == ST_INTG || state == ST_DRV)) begin
      acc <= acc + UW'(mul_result);
    end else if (state == ST_CEIL && acc > ceil_w) begin
      acc <= ceil_w;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      out_data <= drive_next[DW-1:0];
    end
  end

  // checks
  a_done_in_mul_state: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == ST_INC || state == ST_DER || state == ST_PROP ||
                  state == ST_INTG || state == ST_DRV))
    else $error("multiplier finished outside a product step");

  a_accept_starts_tick: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == ST_INC && mul_start))
    else $error("accepted word did not start the integral product");

  a_no_early_done: assert property (@(posedge clk) disable iff (rst)
    mul_start |=> !mul_done)
    else $error("multiplier finished right after load");

  a_out_from_clamp: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_OUT))
    else $error("drive value shown without a finished clamp");

endmodule

/* tb/pid_speed_controller_core_tb.sv */
module pid_speed_controller_core_tb import psc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_W   = DATA_WIDTH_DEF;
  localparam int FRAC_W   = FRACTION_BITS_DEF;
  localparam int IN_BITS  = ((2 * DATA_W + 7) / 8) * 8;
  localparam int OUT_BITS = ((DATA_W + 7) / 8) * 8;

  localparam logic signed [63:0] SUM_MAX  = (64'sd1 <<< (SUM_W - 1)) - 64'sd1;
  localparam logic signed [63:0] SUM_MIN  = -SUM_MAX - 64'sd1;
  localparam logic signed [63:0] DATA_MAX = (64'sd1 <<< (DATA_W - 1)) - 64'sd1;
  localparam logic signed [63:0] DATA_MIN = -DATA_MAX - 64'sd1;
  localparam logic signed [63:0] PROD_MAX = 64'sh7fff_ffff_ffff_ffff;

  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W - 1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VAL_ONE = 1 <<< FRAC_W;

  localparam logic [COEF_W-1:0] GAIN_MAX = 32'h7fff_ffff;
  localparam logic [COEF_W-1:0] GAIN_MIN = 32'h8000_0000;

  // index with no register behind it
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = '1;

  // expected drive values of a fixed-point pid loop, kept in tick order
  class pid_drive_scoreboard;
    logic signed [63:0] kp, ki, kd, dt, inv_dt, lo_limit, hi_limit;
    logic signed [63:0] integral, last_err;
    logic signed [DATA_W-1:0] drive_q[$];
    int failures;

    function new();
      kp = RST_KP;
      ki = RST_KI;
      kd = RST_KD;
      dt = RST_DT;
      inv_dt = RST_INVDT;
      lo_limit = RST_FLOOR;
      hi_limit = RST_CEIL;
      integral = 0;
      last_err = 0;
      failures = 0;
    endfunction

    function logic signed [63:0] clip(input logic signed [63:0] v, lo, hi);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    // 64-bit add that sticks at the ends instead of wrapping
    function logic signed [63:0] sat_sum(input logic signed [63:0] a, b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? ~PROD_MAX : PROD_MAX;
      return s[63:0];
    endfunction

    // exact product, truncated toward zero by the fraction bits, magnitude capped
    function logic signed [63:0] scaled_mul(input logic signed [63:0] a, b);
      logic [63:0] ua, ub, mag;
      logic [127:0] prod;
      ua = a[63] ? -a : a;
      ub = b[63] ? -b : b;
      prod = ({64'd0, ua} * {64'd0, ub}) >> FRAC_W;
      mag = (prod > 128'(PROD_MAX)) ? PROD_MAX : prod[63:0];
      return (a[63] ^ b[63]) ? -mag : mag;
    endfunction

    function void set_register(input logic [REG_IDX_W-1:0] idx,
                               input logic [COEF_W-1:0] value);
      case (idx)
        REG_KP:    kp = $signed(value);
        REG_KI:    ki = $signed(value);
        REG_KD:    kd = $signed(value);
        REG_DT:    dt = value[COEF_W-2:0];
        REG_INVDT: inv_dt = value[COEF_W-2:0];
        REG_FLOOR: lo_limit = $signed(value);
        REG_CEIL:  hi_limit = $signed(value);
        default: ;
      endcase
    endfunction

    // one accepted tick: update integral and last error, queue the drive value
    function void note_tick(input logic signed [DATA_W-1:0] target, measured);
      logic signed [63:0] err, inc, deriv, u;
      err = target - measured;
      inc = clip(scaled_mul(err, dt), SUM_MIN * 2, SUM_MAX * 2);
      integral = clip(integral + inc, SUM_MIN, SUM_MAX);
      deriv = clip(scaled_mul(err - last_err, inv_dt), SUM_MIN, SUM_MAX);
      u = sat_sum(scaled_mul(kp, err), scaled_mul(ki, integral));
      u = sat_sum(u, scaled_mul(kd, deriv));
      // ceiling first, so the floor wins when the two cross
      if (u > hi_limit) u = hi_limit;
      if (u < lo_limit) u = lo_limit;
      u = clip(u, DATA_MIN, DATA_MAX);
      last_err = err;
      drive_q.push_back(u[DATA_W-1:0]);
    endfunction

    function void check_drive(input logic signed [DATA_W-1:0] actual);
      logic signed [DATA_W-1:0] want;
      if (drive_q.size() == 0) begin
        $error("drive_value: expected none, actual %0d", actual);
        failures++;
      end else begin
        want = drive_q.pop_front();
        if (actual !== want) begin
          $error("drive_value: expected %0d, actual %0d", want, actual);
          failures++;
        end
      end
    endfunction

    function int pending();
      return drive_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_BITS-1:0]   s_axis_tdata = '0;   // target_value, measured_value
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_BITS-1:0]  m_axis_tdata;        // drive_value
  logic                 cfg_write = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0]    cfg_data = '0;

  pid_drive_scoreboard drive_sb;

  logic [DATA_W-1:0] sample_edges [4] = '{VAL_MAX, VAL_MIN, '0, '1};

  // sender burst state
  int burst_left = 0;
  int gap_limit = 0;

  // receiver stall pattern state
  int stall_window = 0;
  int stall_period = 1;
  int stall_len = 0;
  int stall_count = 0;

  pid_speed_controller_core #(
    .DATA_WIDTH(DATA_W),
    .FRACTION_BITS(FRAC_W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receive side: check each accepted word, stall on a windowed duty pattern
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      drive_sb.check_drive($signed(m_axis_tdata[DATA_W-1:0]));
    end
    if (stall_window == 0) begin
      stall_window = $urandom_range(64, 512);
      stall_period = $urandom_range(2, 130);
      stall_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, stall_period - 1);
      stall_count = 0;
    end
    stall_window--;
    m_axis_tready <= (stall_count >= stall_len);
    stall_count = (stall_count + 1) % stall_period;
  end

  // one tick word, with a random gap before each burst
  task automatic send_tick(input logic signed [DATA_W-1:0] target,
                           input logic signed [DATA_W-1:0] measured);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (gap_limit == 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, gap_limit);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_BITS'({measured, target});
    do @(posedge clk); while (!s_axis_tready);
    drive_sb.note_tick(target, measured);
  endtask

  // stop sending and wait for every drive value to come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (drive_sb.pending() != 0) @(posedge clk);
  endtask

  // leaves cfg_write high so back-to-back writes can follow each other directly
  task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                input logic [COEF_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    drive_sb.set_register(idx, value);
  endtask

  task automatic apply_settings(input logic [COEF_W-1:0] kp_v, ki_v, kd_v, dt_v, inv_v,
                                input logic [COEF_W-1:0] lo_v, hi_v);
    write_register(REG_KP, kp_v);
    write_register(REG_KI, ki_v);
    write_register(REG_KD, kd_v);
    write_register(REG_DT, dt_v);
    write_register(REG_INVDT, inv_v);
    write_register(REG_FLOOR, lo_v);
    write_register(REG_CEIL, hi_v);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [COEF_W-1:0] rand_gain();
    case ($urandom_range(0, 5))
      0: return GAIN_MAX;
      1: return GAIN_MIN;
      2: return '0;
      3: return $urandom;
      default: return $urandom_range(0, 1) ? $urandom_range(0, 4 << FRAC_W)
                                           : -$urandom_range(0, 4 << FRAC_W);
    endcase
  endfunction

  // top bit is dropped by the unsigned registers, so all-ones is worth a try
  function automatic logic [COEF_W-1:0] rand_step(input int unsigned typical_max);
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? GAIN_MAX : '1;
      1: return '0;
      2: return $urandom;
      default: return $urandom_range(1, typical_max);
    endcase
  endfunction

  initial begin
    logic signed [DATA_W-1:0] setpoint, target, measured;
    logic [COEF_W-1:0] lo_v, hi_v;
    int mode;
    drive_sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset gains and limits, field extremes
    send_tick('0, '0);
    send_tick(VAL_MAX, VAL_MIN);
    send_tick(VAL_MIN, VAL_MAX);
    send_tick(VAL_MAX, VAL_MAX);
    send_tick(VAL_MIN, VAL_MIN);
    send_tick(VAL_ONE, '0);
    drain();

    // all gains at max: integral and derivative saturate, sums overflow
    apply_settings(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MIN, GAIN_MAX);
    repeat (3) send_tick(VAL_MAX, VAL_MIN);
    repeat (3) send_tick(VAL_MIN, VAL_MAX);
    send_tick('0, '0);
    drain();

    // negative gains, zero steps, floor above ceiling, write to an unused index
    write_register(REG_UNUSED, GAIN_MAX);
    apply_settings(GAIN_MIN, GAIN_MIN, GAIN_MIN, '0, '0, 32'sd1000 <<< FRAC_W,
                   -(32'sd1000 <<< FRAC_W));
    send_tick(VAL_ONE, '0);
    send_tick(VAL_MIN, VAL_MAX);
    send_tick(VAL_MAX, VAL_MIN);
    send_tick('0, '0);
    drain();

    // random settings, with half of the ticks tracking around a setpoint
    for (int phase = 0; phase < 8; phase++) begin
      if ($urandom_range(0, 2) == 0) write_register(REG_UNUSED, $urandom);
      case ($urandom_range(0, 3))
        0: begin
          lo_v = $urandom;
          hi_v = $urandom;
        end
        1: begin
          lo_v = GAIN_MIN;
          hi_v = GAIN_MAX;
        end
        default: begin
          lo_v = -$urandom_range(1, 1 << 22);
          hi_v = $urandom_range(1, 1 << 22);
        end
      endcase
      apply_settings(rand_gain(), rand_gain(), rand_gain(), rand_step(1 << 17),
                     rand_step(1 << 24), lo_v, hi_v);
      case ($urandom_range(0, 3))
        0: gap_limit = 0;
        1: gap_limit = 8;
        2: gap_limit = 30;
        default: gap_limit = 70;
      endcase
      setpoint = $urandom_range(0, 1 << 24) - (1 << 23);
      for (int n = 0; n < 250; n++) begin
        if ($urandom_range(0, 39) == 0) setpoint = $urandom_range(0, 1 << 24) - (1 << 23);
        mode = $urandom_range(0, 19);
        if (mode < 10) begin
          target = setpoint;
          measured = setpoint + $urandom_range(0, 1 << 21) - (1 << 20);
        end else if (mode < 15) begin
          target = $urandom;
          measured = $urandom;
        end else if (mode < 17) begin
          target = sample_edges[$urandom_range(0, 3)];
          measured = sample_edges[$urandom_range(0, 3)];
        end else begin
          target = $urandom_range(0, 1 << 19) - (1 << 18);
          measured = $urandom_range(0, 1 << 19) - (1 << 18);
        end
        send_tick(target, measured);
      end
      drain();
    end

    // latency window for any stray word
    repeat (80) @(posedge clk);
    if (drive_sb.failures == 0 && drive_sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* pid_speed_controller_core.f */
hw/rtl/psc_pkg.sv
hw/rtl/psc_serial_mul.sv
hw/rtl/pid_speed_controller_core.sv
tb/pid_speed_controller_core_tb.sv
